FILE: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU/LRU replacement tracker.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int WAYS   = 16;
  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int TREE_P = 1 << IDX_W;     // leaves of the victim tree, padded
  localparam int S1_LVL = IDX_W / 2;      // tree levels resolved in lookup cycle
  localparam int S2_LVL = IDX_W - S1_LVL; // tree levels resolved in update cycle
  localparam int MID_P  = TREE_P >> S1_LVL;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PICK
  } state_t;

  typedef struct packed {
    logic load;  // capture request key
    logic look;  // key compare, first half of victim tree
    logic pick;  // finish victim tree, update entries, load result
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } stat_t;

endpackage

FILE: src/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept, lookup, update; one request in flight at a time.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lfu_pkg::stat_t stat,
  output lfu_pkg::cmd_t  cmd
);

  lfu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      lfu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lfu_pkg::ST_LOOK;
        end
      end
      lfu_pkg::ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = lfu_pkg::ST_PICK;
      end
      lfu_pkg::ST_PICK: begin
        // update only once the result register can take the new result
        if (!stat.out_busy) begin
          cmd.pick   = 1'b1;
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Entry array, key compare, two-stage victim tree, counters, result register.
// ----------------------------------------------------------------------------
module lfu_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lfu_pkg::cmd_t              cmd,
  output lfu_pkg::stat_t             stat,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_data,
  input  logic [31:0]                block_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic                       evicted,
  output logic [31:0]                evicted_id,
  output logic [31:0]                miss_total
);

  typedef struct packed {
    logic                      valid;
    logic [31:0]               uses;
    logic [31:0]               age;
    logic [31:0]               key;
    logic [lfu_pkg::IDX_W-1:0] idx;
  } cand_t;

  // lower use count wins, then larger age; ties keep a (lower index)
  function automatic cand_t better(cand_t a, cand_t b);
    logic take_b;
    take_b = b.valid && (!a.valid || (b.uses < a.uses) ||
                         ((b.uses == a.uses) && (b.age > a.age)));
    return take_b ? b : a;
  endfunction

  logic [lfu_pkg::CAP_W-1:0] cap;
  logic [lfu_pkg::WAYS-1:0]  ent_valid;
  logic [31:0]               ent_key   [lfu_pkg::WAYS];
  logic [31:0]               ent_uses  [lfu_pkg::WAYS];
  logic [31:0]               ent_stamp [lfu_pkg::WAYS];
  logic [31:0]               acc_num;
  logic [31:0]               miss_cnt;
  logic [31:0]               key_q;

  // lookup results
  logic                      hit_q;
  logic [lfu_pkg::IDX_W-1:0] hit_idx_q;
  logic [31:0]               hit_uses_q;
  logic                      full_q;
  logic [lfu_pkg::IDX_W-1:0] free_idx_q;
  cand_t                     mid_q [lfu_pkg::MID_P];

  logic                      hit_c;
  logic [lfu_pkg::IDX_W-1:0] hit_idx_c;
  logic [31:0]               hit_uses_c;
  logic [lfu_pkg::IDX_W-1:0] free_idx_c;
  logic [lfu_pkg::CNT_W-1:0] count_c;
  logic [31:0]               eff_cap_c;
  logic                      full_c;
  cand_t                     t1 [lfu_pkg::TREE_P];
  cand_t                     t2 [lfu_pkg::MID_P];
  cand_t                     win;

  logic [31:0]               miss_next;
  logic                      do_evict;
  logic [lfu_pkg::IDX_W-1:0] slot;

  assign stat.out_busy = out_valid && out_stall;

  // key compare, occupancy, lowest free slot
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    hit_uses_c = '0;
    free_idx_c = '0;
    for (int i = lfu_pkg::WAYS - 1; i >= 0; i--) begin
      if (ent_valid[i] && (ent_key[i] == key_q)) begin
        hit_c      = 1'b1;
        hit_idx_c  = lfu_pkg::IDX_W'(i);
        hit_uses_c = ent_uses[i];
      end
      if (!ent_valid[i]) begin
        free_idx_c = lfu_pkg::IDX_W'(i);
      end
    end
    count_c = lfu_pkg::CNT_W'($countones(ent_valid));
    if (cap == '0) begin
      eff_cap_c = 32'd1;
    end else if (32'(cap) > 32'(lfu_pkg::WAYS)) begin
      eff_cap_c = 32'(lfu_pkg::WAYS);
    end else begin
      eff_cap_c = 32'(cap);
    end
    full_c = 32'(count_c) >= eff_cap_c;
  end

  // victim tree, first levels (in place: slot i reads 2i and 2i+1)
  always_comb begin
    for (int i = 0; i < lfu_pkg::TREE_P; i++) begin
      t1[i] = '0;
      if (i < lfu_pkg::WAYS) begin
        t1[i].valid = ent_valid[i];
        t1[i].uses  = ent_uses[i];
        t1[i].age   = acc_num - ent_stamp[i];
        t1[i].key   = ent_key[i];
        t1[i].idx   = lfu_pkg::IDX_W'(i);
      end
    end
    for (int l = 0; l < lfu_pkg::S1_LVL; l++) begin
      for (int i = 0; i < lfu_pkg::TREE_P / 2; i++) begin
        if (i < (lfu_pkg::TREE_P >> (l + 1))) begin
          t1[i] = better(t1[2*i], t1[2*i+1]);
        end
      end
    end
  end

  // victim tree, remaining levels
  always_comb begin
    for (int i = 0; i < lfu_pkg::MID_P; i++) begin
      t2[i] = mid_q[i];
    end
    for (int l = 0; l < lfu_pkg::S2_LVL; l++) begin
      for (int i = 0; i < lfu_pkg::MID_P / 2; i++) begin
        if (i < (lfu_pkg::MID_P >> (l + 1))) begin
          t2[i] = better(t2[2*i], t2[2*i+1]);
        end
      end
    end
    win = t2[0];
  end

  assign miss_next = (miss_cnt == 32'hFFFF_FFFF) ? miss_cnt : miss_cnt + 32'd1;
  assign do_evict  = !hit_q && full_q;
  assign slot      = full_q ? win.idx : free_idx_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= lfu_pkg::CAP_RESET;
      ent_valid <= '0;
      acc_num   <= '0;
      miss_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (cmd.pick) begin
        out_valid <= 1'b1;
        acc_num   <= acc_num + 32'd1;
        if (!hit_q) begin
          miss_cnt <= miss_next;
          for (int i = 0; i < lfu_pkg::WAYS; i++) begin
            if (slot == lfu_pkg::IDX_W'(i)) begin
              ent_valid[i] <= 1'b1;
            end
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= block_id;
    end
    if (cmd.look) begin
      hit_q      <= hit_c;
      hit_idx_q  <= hit_idx_c;
      hit_uses_q <= hit_uses_c;
      full_q     <= full_c;
      free_idx_q <= free_idx_c;
      for (int i = 0; i < lfu_pkg::MID_P; i++) begin
        mid_q[i] <= t1[i];
      end
    end
    if (cmd.pick) begin
      for (int i = 0; i < lfu_pkg::WAYS; i++) begin
        if (hit_q && (hit_idx_q == lfu_pkg::IDX_W'(i))) begin
          if (hit_uses_q != 32'hFFFF_FFFF) begin
            ent_uses[i] <= hit_uses_q + 32'd1;
          end
          ent_stamp[i] <= acc_num;
        end else if (!hit_q && (slot == lfu_pkg::IDX_W'(i))) begin
          ent_key[i]   <= key_q;
          ent_uses[i]  <= 32'd1;
          ent_stamp[i] <= acc_num;
        end
      end
      hit        <= hit_q;
      evicted    <= do_evict;
      evicted_id <= do_evict ? win.key : 32'd0;
      miss_total <= hit_q ? miss_cnt : miss_next;
    end
  end

endmodule

FILE: src/lfu_lru_tiebreak_replacement.sv
// ----------------------------------------------------------------------------
// lfu_lru_tiebreak_replacement
// Fully associative LFU replacement tracker, oldest stamp breaks ties.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_stall  | block_id[31:0]
//  out      | out_valid / out_stall| hit, evicted, evicted_id, miss_total
//  cfg      | cfg_we               | cfg_data[4:0] (capacity_in_use)
//
//  A request passes through accept, lookup (key compare over all ways and
//  the first half of the victim tree), update (rest of the tree, entry write,
//  result load). The next request is accepted in the cycle after the update.
//  The update waits while the result register is full and stalled.
//  Synchronous reset clears the valid bits and counters and sets the capacity (16).
// ----------------------------------------------------------------------------
module lfu_lru_tiebreak_replacement (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               block_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic                      evicted,
  output logic [31:0]               evicted_id,
  output logic [31:0]               miss_total,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

  lfu_pkg::cmd_t  cmd;
  lfu_pkg::stat_t stat;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .block_id   (block_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_id (evicted_id),
    .miss_total (miss_total)
  );

endmodule

FILE: src/lfu_chk.sv
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks for the replacement tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        evicted,
  input logic [31:0] evicted_id
);

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted)
    else $error("eviction reported on a hit");

  a_evict_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (evicted_id == 32'd0))
    else $error("evicted_id nonzero without eviction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(evicted_id) && $stable(hit)))
    else $error("stalled result changed");

endmodule

bind lfu_lru_tiebreak_replacement lfu_chk u_lfu_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hit        (hit),
  .evicted    (evicted),
  .evicted_id (evicted_id)
);

FILE: sim/lfu_replacement_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_replacement_monitor
// Watches the request, result and capacity ports of the replacement tracker.
// It keeps its own copy of the ways and counters, predicts the result of each
// accepted request, and compares every result, field by field, with the
// oldest prediction that is still waiting.
// ----------------------------------------------------------------------------
module lfu_replacement_monitor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [31:0]               block_id,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      hit,
  input  logic                      evicted,
  input  logic [31:0]               evicted_id,
  input  logic [31:0]               miss_total,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
  output int                        error_count,
  output int                        waiting,
  output int                        hit_count,
  output int                        evict_count
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] evicted_id;
    logic [31:0] miss_total;
  } outcome_t;

  logic                      way_valid [lfu_pkg::WAYS];
  logic [31:0]               way_key   [lfu_pkg::WAYS];
  logic [31:0]               way_uses  [lfu_pkg::WAYS];
  logic [31:0]               way_stamp [lfu_pkg::WAYS];
  logic [31:0]               access_no;
  logic [31:0]               misses;
  logic [lfu_pkg::CAP_W-1:0] capacity;

  outcome_t outcome_q [$];
  outcome_t want;
  outcome_t next_outcome;
  int       errors;
  int       hits;
  int       evictions;
  int       results_seen;

  initial begin
    error_count = 0;
    waiting     = 0;
    hit_count   = 0;
    evict_count = 0;
  end

  // One access: LFU victim, oldest stamp (wrap-safe age) breaks ties,
  // lowest index breaks full ties.
  function automatic outcome_t lookup_and_replace(input logic [31:0] key);
    outcome_t    r;
    int          i;
    int          found;
    int          slot;
    int          live;
    int          limit;
    logic [31:0] best_uses;
    logic [31:0] best_age;
    logic [31:0] age;
    r         = '0;
    found     = -1;
    slot      = -1;
    live      = 0;
    best_uses = '0;
    best_age  = '0;
    limit     = (capacity == 0) ? 1 :
                (capacity > lfu_pkg::WAYS) ? lfu_pkg::WAYS : int'(capacity);
    for (i = 0; i < lfu_pkg::WAYS; i++) begin
      if (way_valid[i]) begin
        live++;
        if (found < 0 && way_key[i] == key) found = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (way_uses[found] != 32'hFFFF_FFFF) way_uses[found] = way_uses[found] + 1;
      way_stamp[found] = access_no;
    end else begin
      if (misses != 32'hFFFF_FFFF) misses = misses + 1;
      if (live >= limit) begin
        for (i = 0; i < lfu_pkg::WAYS; i++) begin
          if (way_valid[i]) begin
            age = access_no - way_stamp[i];
            if (slot < 0 || way_uses[i] < best_uses ||
                (way_uses[i] == best_uses && age > best_age)) begin
              slot      = i;
              best_uses = way_uses[i];
              best_age  = age;
            end
          end
        end
        if (slot >= 0) begin
          r.evicted    = 1'b1;
          r.evicted_id = way_key[slot];
        end
      end else begin
        for (i = lfu_pkg::WAYS - 1; i >= 0; i--) begin
          if (!way_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        way_valid[slot] = 1'b1;
        way_key[slot]   = key;
        way_uses[slot]  = 32'd1;
        way_stamp[slot] = access_no;
      end
    end
    access_no    = access_no + 1;
    r.miss_total = misses;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (errors < PRINT_LIMIT)
      $display("%0t: result %0d: %s got %h, expected %h",
               $realtime, results_seen, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfu_pkg::WAYS; i++) way_valid[i] = 1'b0;
      access_no = '0;
      misses    = '0;
      capacity  = lfu_pkg::CAP_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_we) capacity = cfg_data;
      // results first, so a result cannot be matched to a request that
      // arrives at the same edge
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending, miss_total",
                          miss_total, '0);
        end else begin
          want = outcome_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (evicted !== want.evicted)
            report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
          if (evicted_id !== want.evicted_id)
            report_mismatch("evicted_id", evicted_id, want.evicted_id);
          if (miss_total !== want.miss_total)
            report_mismatch("miss_total", miss_total, want.miss_total);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        next_outcome = lookup_and_replace(block_id);
        if (next_outcome.hit) hits++;
        if (next_outcome.evicted) evictions++;
        outcome_q = {outcome_q, next_outcome};
      end
    end
    error_count <= errors;
    waiting     <= outcome_q.size();
    hit_count   <= hits;
    evict_count <= evictions;
  end

endmodule

FILE: sim/lfu_lru_tiebreak_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_lru_tiebreak_replacement_tb
// Drives block requests and capacity settings into the replacement tracker.
// A short directed opening covers extreme keys, hits, capacity below the
// valid count, capacity zero and capacity above the way count; random phases
// then reuse small key pools so hits, LFU victims and oldest-stamp ties all
// occur. Both channels idle at random, with one phase free of gaps.
// ----------------------------------------------------------------------------
module lfu_lru_tiebreak_replacement_tb;

  localparam int STALL_PCT      = 29;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_REQS     = 148;
  localparam int POOL_MAX       = 24;
  localparam int NUM_PHASES     = 9;
  localparam int STEADY_PHASE   = 3;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [31:0]               block_id;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hit;
  logic                      evicted;
  logic [31:0]               evicted_id;
  logic [31:0]               miss_total;
  logic                      cfg_we;
  logic [lfu_pkg::CAP_W-1:0] cfg_data;

  logic                      steady;
  int                        error_count;
  int                        waiting;
  int                        hit_count;
  int                        evict_count;
  int                        sent;
  int                        settings;
  int                        idle_cycles;
  logic [31:0]               key_pool [POOL_MAX];
  logic [lfu_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];

  lfu_lru_tiebreak_replacement dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .block_id   (block_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_id (evicted_id),
    .miss_total (miss_total),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  lfu_replacement_monitor mon (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .block_id    (block_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_id  (evicted_id),
    .miss_total  (miss_total),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .waiting     (waiting),
    .hit_count   (hit_count),
    .evict_count (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, waiting);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high from one request to the next unless a gap is taken
  task automatic send_request(input logic [31:0] key);
    if (!steady) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    block_id <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // let the monitor see the last accepted request before reading waiting
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  initial begin
    int eff;
    int pool_n;
    int hot_n;
    int pick;
    rst         = 1'b1;
    in_valid    = 1'b0;
    block_id    = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    steady      = 1'b0;
    sent        = 0;
    settings    = 1;
    idle_cycles = 0;
    phase_caps  = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd12, 5'd17, 5'd2,
                    lfu_pkg::CAP_W'($urandom_range(0, 31))};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: extreme keys, repeated hits
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h8000_0000);
    send_request(32'h0000_0001);
    send_request(32'h7FFF_FFFE);

    // capacity below the valid count: each miss evicts one, the oldest
    // of the single-use entries
    set_capacity(5'd2);
    send_request(32'h1234_5678);
    send_request(32'h9ABC_DEF0);
    send_request(32'h1234_5678);
    send_request(32'hDEAD_BEEF);

    // zero acts as one
    set_capacity(5'd0);
    send_request(32'h5555_5555);
    send_request(32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA);

    // above the way count acts as the way count
    set_capacity(5'd31);
    repeat (6) send_request($urandom);

    // counter saturation and stamp wrap need 2^32 requests, out of reach here
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(phase_caps[ph]);
      steady = (ph == STEADY_PHASE);
      eff    = (phase_caps[ph] == 0) ? 1 :
               (phase_caps[ph] > lfu_pkg::WAYS) ? lfu_pkg::WAYS : int'(phase_caps[ph]);
      pool_n = eff + $urandom_range(1, 8);
      hot_n  = (pool_n + 3) / 4;
      for (int k = 0; k < pool_n; k++) key_pool[k] = $urandom;
      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) send_request($urandom);
        else if (pick < 50) send_request(key_pool[$urandom_range(0, hot_n - 1)]);
        else send_request(key_pool[$urandom_range(0, pool_n - 1)]);
      end
    end
    steady = 1'b0;
    drain();

    $display("%0d requests over %0d capacity settings: %0d hits, %0d evictions",
             sent, settings, hit_count, evict_count);
    if (error_count == 0 && waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, waiting);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_lru_tiebreak_replacement.sv
src/lfu_chk.sv
sim/lfu_replacement_monitor.sv
sim/lfu_lru_tiebreak_replacement_tb.sv
